// ===== src/lwpc_pkg.sv =====
// Shared types and constants for the LRU write-back page cache.
// No dependencies; every other file of the block refers to this package by scoped names.
package lwpc_pkg;

  // Fixed field widths of the request and response
  localparam int unsigned PAGE_W = 24;
  localparam int unsigned CFG_W  = 7;
  localparam int unsigned SLOT_W = 6;

  // Defaults for the top-level parameters
  localparam int unsigned ENTRIES_DEF     = 64;
  localparam int unsigned AGE_W_DEF       = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Reset value of the active slot count register
  localparam logic [CFG_W-1:0] ACTIVE_RST = CFG_W'(64);

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              is_write;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [PAGE_W-1:0] victim_page;
    logic              writeback;
  } rsp_t;

  // Request as queued for the lookup engine, with its effective slot limit
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              is_write;
    logic [CFG_W-1:0]  limit;
  } job_t;

  // Fill status of the request queue
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== src/lru_writeback_page_cache.sv =====
// Top level of the fully associative LRU write-back page cache.
// Depends on lwpc_pkg, lwpc_front, lwpc_queue and lwpc_back.
//
// A request (page, read/write flag) is taken at a clock edge with start high and busy low;
// a two-entry queue lets a new request in while the lookup engine works on an earlier one.
// Each request gives exactly one response, shown on rsp_o for a single cycle with done_o
// high; the receiver cannot stall it, so it must sample rsp_o whenever done_o is set.
// A request is popped by the lookup engine, which then scans n slots and updates one, where n is the
// smaller of the active slot count and the number of filled slots: the engine reads one slot
// per cycle through a single memory read port, comparing its page and tracking the oldest age,
// stopping early at the first match. No clearing pass follows reset. The active slot
// count is written on the cfg channel, which is always ready, and is to be changed only
// while no request is pending.
module lru_writeback_page_cache #(
  parameter int unsigned ENTRIES     = lwpc_pkg::ENTRIES_DEF,
  parameter int unsigned AGE_WIDTH   = lwpc_pkg::AGE_W_DEF,
  parameter int unsigned QUEUE_DEPTH = lwpc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  lwpc_pkg::req_t             req_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lwpc_pkg::CFG_W-1:0] cfg_data_i,
  output logic                       done_o,
  output lwpc_pkg::rsp_t             rsp_o
);

  lwpc_pkg::q_status_t q_status;
  lwpc_pkg::job_t      push_job;
  lwpc_pkg::job_t      head_job;
  logic                push;
  logic                pop;

  lwpc_front #(
    .ENTRIES(ENTRIES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (push_job)
  );

  lwpc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .status_o(q_status)
  );

  lwpc_back #(
    .ENTRIES  (ENTRIES),
    .AGE_WIDTH(AGE_WIDTH)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(q_status),
    .job_i   (head_job),
    .pop_o   (pop),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

endmodule

// ===== src/lwpc_front.sv =====
// Front end of the page cache: command accept, active slot register and limit clamping.
// Depends on lwpc_pkg; feeds lwpc_queue.
module lwpc_front #(
  parameter int unsigned ENTRIES = lwpc_pkg::ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  lwpc_pkg::req_t                 req_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lwpc_pkg::CFG_W-1:0]     cfg_data_i,
  input  lwpc_pkg::q_status_t            q_status_i,
  output logic                           push_o,
  output lwpc_pkg::job_t                 job_o
);

  localparam int unsigned CFG_MAX = (1 << lwpc_pkg::CFG_W) - 1;
  localparam int unsigned CAP     = (ENTRIES < CFG_MAX) ? ENTRIES : CFG_MAX;
  localparam logic [lwpc_pkg::CFG_W-1:0] CAP_V = lwpc_pkg::CFG_W'(CAP);
  localparam logic [lwpc_pkg::CFG_W-1:0] ONE_V = lwpc_pkg::CFG_W'(1);

  logic [lwpc_pkg::CFG_W-1:0] active_q, active_d;
  logic [lwpc_pkg::CFG_W-1:0] limit;

  // Take configuration writes at any time
  assign cfg_ready_o = 1'b1;

  always_comb begin
    active_d = active_q;
    if (cfg_valid_i) begin
      active_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= lwpc_pkg::ACTIVE_RST;
    end else begin
      active_q <= active_d;
    end
  end

  // Clamp the slot count: zero acts as one, anything above the array acts as its size
  always_comb begin
    if (active_q == '0) begin
      limit = ONE_V;
    end else if (active_q > CAP_V) begin
      limit = CAP_V;
    end else begin
      limit = active_q;
    end
  end

  // Accept a request whenever the queue has room
  assign busy   = q_status_i.full;
  assign push_o = start && !busy;

  always_comb begin
    job_o.page     = req_i.page;
    job_o.is_write = req_i.is_write;
    job_o.limit    = limit;
  end

endmodule

// ===== src/lwpc_queue.sv =====
// Short request queue between the front end and the lookup engine.
// Depends on lwpc_pkg for the queued request type.
module lwpc_queue #(
  parameter int unsigned DEPTH = lwpc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lwpc_pkg::job_t      job_i,
  input  logic                pop_i,
  output lwpc_pkg::job_t      job_o,
  output lwpc_pkg::q_status_t status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  lwpc_pkg::job_t   store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign status_o.full  = (count_q == FULL_CNT);
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign job_o          = store_q[rd_ptr_q];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold queued requests
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== src/lwpc_back.sv =====
// Lookup engine of the page cache: slot scan for tag match and oldest age, then update.
// Depends on lwpc_pkg; takes requests from lwpc_queue and drives the response strobe.
module lwpc_back #(
  parameter int unsigned ENTRIES   = lwpc_pkg::ENTRIES_DEF,
  parameter int unsigned AGE_WIDTH = lwpc_pkg::AGE_W_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lwpc_pkg::q_status_t status_i,
  input  lwpc_pkg::job_t      job_i,
  output logic                pop_o,
  output logic                done_o,
  output lwpc_pkg::rsp_t      rsp_o
);

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned FILL_W = $clog2(ENTRIES + 1);
  localparam int unsigned CNT_W  = (FILL_W > lwpc_pkg::CFG_W) ? FILL_W : lwpc_pkg::CFG_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  // Slot storage: page, dirty mark and age, one read and one write per cycle
  logic [lwpc_pkg::PAGE_W-1:0] page_mem  [ENTRIES];
  logic                        dirty_mem [ENTRIES];
  logic [AGE_WIDTH-1:0]        age_mem   [ENTRIES];

  logic [lwpc_pkg::PAGE_W-1:0] rd_page_q;
  logic                        rd_dirty_q;
  logic [AGE_WIDTH-1:0]        rd_age_q;

  logic [1:0]           state_q, state_d;
  logic [CNT_W-1:0]     cur_q, cur_d;
  logic [CNT_W-1:0]     len_q, len_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic                 recent_valid_q, recent_valid_d;
  logic [IDX_W-1:0]     recent_idx_q, recent_idx_d;
  logic [AGE_WIDTH-1:0] recent_age_q, recent_age_d;
  logic                 done_q, done_d;

  lwpc_pkg::job_t              job_q;
  lwpc_pkg::rsp_t              rsp_q;
  logic                        hit_q;
  logic [IDX_W-1:0]            hit_idx_q;
  logic [IDX_W-1:0]            min_idx_q;
  logic [AGE_WIDTH-1:0]        min_age_q;
  logic [lwpc_pkg::PAGE_W-1:0] min_page_q;
  logic                        min_dirty_q;

  logic [CNT_W-1:0]     lim_head, lim_job, fill_ext, scan_len;
  logic [IDX_W-1:0]     rd_addr, cur_idx, upd_idx;
  logic                 match, last, take_min, room, evict;
  logic [AGE_WIDTH-1:0] base_age, new_age;
  logic                 page_we, dirty_we, age_we;

  assign lim_head = CNT_W'(job_i.limit);
  assign lim_job  = CNT_W'(job_q.limit);
  assign fill_ext = CNT_W'(fill_q);
  assign scan_len = (lim_head < fill_ext) ? lim_head : fill_ext;

  // Scan compare on the slot read in the previous cycle
  assign cur_idx  = IDX_W'(cur_q);
  assign rd_addr  = (state_q == ST_IDLE) ? '0 : IDX_W'(cur_q + CNT_W'(1));
  assign match    = (rd_page_q == job_q.page);
  assign last     = (cur_q == len_q - CNT_W'(1));
  assign take_min = (cur_q == '0) || (rd_age_q < min_age_q);

  // Pick the slot to update and form its new age
  assign room  = (fill_ext < lim_job);
  assign evict = !hit_q && !room;

  always_comb begin
    if (hit_q) begin
      upd_idx  = hit_idx_q;
      base_age = recent_age_q;
    end else if (room) begin
      upd_idx  = IDX_W'(fill_q);
      base_age = recent_age_q;
    end else begin
      upd_idx  = min_idx_q;
      base_age = (recent_valid_q && (recent_idx_q == min_idx_q)) ? '0 : recent_age_q;
    end
    new_age = (&base_age) ? base_age : base_age + AGE_WIDTH'(1);
  end

  assign page_we  = (state_q == ST_UPDATE) && !hit_q;
  assign dirty_we = (state_q == ST_UPDATE) && (!hit_q || job_q.is_write);
  assign age_we   = (state_q == ST_UPDATE);

  // Sequencer: pop, scan, update
  always_comb begin
    state_d        = state_q;
    cur_d          = cur_q;
    len_d          = len_q;
    fill_d         = fill_q;
    recent_valid_d = recent_valid_q;
    recent_idx_d   = recent_idx_q;
    recent_age_d   = recent_age_q;
    done_d         = 1'b0;
    pop_o          = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!status_i.empty) begin
          pop_o   = 1'b1;
          len_d   = scan_len;
          cur_d   = '0;
          state_d = (scan_len == '0) ? ST_UPDATE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match || last) begin
          state_d = ST_UPDATE;
        end else begin
          cur_d = cur_q + CNT_W'(1);
        end
      end
      ST_UPDATE: begin
        if (!hit_q && room) begin
          fill_d = fill_q + FILL_W'(1);
        end
        recent_valid_d = 1'b1;
        recent_idx_d   = upd_idx;
        recent_age_d   = new_age;
        done_d         = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cur_q          <= '0;
      len_q          <= '0;
      fill_q         <= '0;
      recent_valid_q <= 1'b0;
      recent_idx_q   <= '0;
      recent_age_q   <= '0;
      done_q         <= 1'b0;
    end else begin
      state_q        <= state_d;
      cur_q          <= cur_d;
      len_q          <= len_d;
      fill_q         <= fill_d;
      recent_valid_q <= recent_valid_d;
      recent_idx_q   <= recent_idx_d;
      recent_age_q   <= recent_age_d;
      done_q         <= done_d;
    end
  end

  // Capture the request, track the first match and the oldest slot, build the response
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      hit_q <= 1'b0;
    end
    if (state_q == ST_SCAN) begin
      if (match) begin
        hit_q     <= 1'b1;
        hit_idx_q <= cur_idx;
      end else if (take_min) begin
        min_idx_q   <= cur_idx;
        min_age_q   <= rd_age_q;
        min_page_q  <= rd_page_q;
        min_dirty_q <= rd_dirty_q;
      end
    end
    if (state_q == ST_UPDATE) begin
      rsp_q.hit         <= hit_q;
      rsp_q.slot        <= lwpc_pkg::SLOT_W'(upd_idx);
      rsp_q.evicted     <= evict;
      rsp_q.victim_page <= evict ? min_page_q : '0;
      rsp_q.writeback   <= evict && min_dirty_q;
    end
  end

  // Slot memories with registered read
  always_ff @(posedge clk_i) begin
    if (page_we) begin
      page_mem[upd_idx] <= job_q.page;
    end
    if (dirty_we) begin
      dirty_mem[upd_idx] <= job_q.is_write;
    end
    if (age_we) begin
      age_mem[upd_idx] <= new_age;
    end
    rd_page_q  <= page_mem[rd_addr];
    rd_dirty_q <= dirty_mem[rd_addr];
    rd_age_q   <= age_mem[rd_addr];
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== src/lwpc_checker.sv =====
// Port-level checks for the LRU write-back page cache, bound to the top level.
// Depends on lwpc_pkg and lru_writeback_page_cache.
module lwpc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input lwpc_pkg::rsp_t rsp_o
);

  // Response strobes never come back to back
  a_done_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("response strobes in back-to-back cycles");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.hit) |-> !rsp_o.evicted)
    else $error("hit reported together with an eviction");

  // Without an eviction the victim fields are clear
  a_no_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.evicted) |-> (rsp_o.victim_page == '0 && !rsp_o.writeback))
    else $error("victim fields set without an eviction");

  // Busy rises only after a request was taken
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted request");

endmodule

bind lru_writeback_page_cache lwpc_checker u_lwpc_checker (.*);
